// ===== rtl/bezier_curve_sampler_unit_assert.svh =====
// Assertion macros for the sampler top level.
`ifndef BEZIER_CURVE_SAMPLER_UNIT_ASSERT_SVH
`define BEZIER_CURVE_SAMPLER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only while reset is released.
`define BZS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("bezier sampler check failed");

// Checked on every edge, reset included.
`define BZS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("bezier sampler reset check failed");

`else

`define BZS_ASSERT(lbl, clk, rstn, prop)
`define BZS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== rtl/bzs_pkg.sv =====
// Shared constants, types and pipeline control struct for the Bezier sampler.
package bzs_pkg;

    // Curve parameter t = i / SAMPLE_DIV; the divisor is a power of two.
    localparam int DIV_LOG2   = 8;
    localparam int SAMPLES    = (2 ** DIV_LOG2) + 1;
    localparam int SAMPLE_DIV = SAMPLES - 1;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int OUT_BITS   = 24;

    localparam int IDX_W  = DIV_LOG2 + 1;
    localparam int SQ_W   = 2 * DIV_LOG2 + 1;
    localparam int WGT_W  = 3 * DIV_LOG2 + 1;
    localparam int PROD_W = WGT_W + 1 + COORD_BITS;
    localparam int SUM_W  = PROD_W + 1;
    localparam int ACC_W  = PROD_W + 2;

    // All weights are scaled to a common denominator of SAMPLE_DIV cubed.
    localparam int RND_SHIFT = 3 * DIV_LOG2 - FRAC_BITS;

    localparam int NUM_STAGES = 6;
    localparam int NUM_CTRL   = 4;

    typedef enum logic {
        OP_QUAD  = 1'b0,
        OP_CUBIC = 1'b1
    } op_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [WGT_W-1:0]             weight_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic signed [OUT_BITS-1:0]   pos_t;

    // Per-stage load enables; bit 0 is the first stage.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctl_t;

endpackage

// ===== rtl/bzs_weights.sv =====
// Bernstein weight pipeline: clamp index, form powers, build the four weights.
module bzs_weights (
    input  logic               aclk,
    input  bzs_pkg::pipe_ctl_t ctl,
    input  bzs_pkg::op_t       opcode,
    input  bzs_pkg::idx_t      sample_index,
    output bzs_pkg::weight_t   weight [bzs_pkg::NUM_CTRL]
);

    localparam int PRD_W = bzs_pkg::SQ_W + bzs_pkg::IDX_W;

    // Stage 1: clamped index and its complement
    bzs_pkg::idx_t i1_reg, u1_reg;
    bzs_pkg::op_t  op1_reg;
    bzs_pkg::idx_t i_clamp;

    // Stage 2: second order terms
    logic [bzs_pkg::SQ_W-1:0] uu_reg, ui_reg, ii_reg;
    bzs_pkg::idx_t            i2_reg, u2_reg;
    bzs_pkg::op_t             op2_reg;

    // Stage 3: weights
    bzs_pkg::weight_t w_reg [bzs_pkg::NUM_CTRL];
    bzs_pkg::weight_t w_next [bzs_pkg::NUM_CTRL];

    logic [PRD_W-1:0]            uuu, uui, uii, iii;
    logic [bzs_pkg::WGT_W:0]     ui_dbl;

    function automatic bzs_pkg::weight_t times3(logic [PRD_W-1:0] v);
        logic [PRD_W+1:0] s;
        s = {1'b0, v, 1'b0} + {2'b00, v};
        return s[bzs_pkg::WGT_W-1:0];
    endfunction

    always_comb begin
        if (sample_index > bzs_pkg::IDX_W'(bzs_pkg::SAMPLE_DIV)) begin
            i_clamp = bzs_pkg::IDX_W'(bzs_pkg::SAMPLE_DIV);
        end else begin
            i_clamp = sample_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            i1_reg  <= i_clamp;
            u1_reg  <= bzs_pkg::IDX_W'(bzs_pkg::SAMPLE_DIV) - i_clamp;
            op1_reg <= opcode;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[1]) begin
            uu_reg  <= u1_reg * u1_reg;
            ui_reg  <= u1_reg * i1_reg;
            ii_reg  <= i1_reg * i1_reg;
            u2_reg  <= u1_reg;
            i2_reg  <= i1_reg;
            op2_reg <= op1_reg;
        end
    end

    always_comb begin
        uuu    = uu_reg * u2_reg;
        uui    = uu_reg * i2_reg;
        uii    = ii_reg * u2_reg;
        iii    = ii_reg * i2_reg;
        ui_dbl = {ui_reg, 1'b0, {bzs_pkg::DIV_LOG2{1'b0}}};
        case (op2_reg)
            bzs_pkg::OP_CUBIC: begin
                w_next[0] = uuu[bzs_pkg::WGT_W-1:0];
                w_next[1] = times3(uui);
                w_next[2] = times3(uii);
                w_next[3] = iii[bzs_pkg::WGT_W-1:0];
            end
            default: begin
                // scale the quadratic weights up to the cubic denominator
                w_next[0] = {uu_reg, {bzs_pkg::DIV_LOG2{1'b0}}};
                w_next[1] = ui_dbl[bzs_pkg::WGT_W-1:0];
                w_next[2] = {ii_reg, {bzs_pkg::DIV_LOG2{1'b0}}};
                w_next[3] = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            w_reg <= w_next;
        end
    end

    assign weight = w_reg;

endmodule

// ===== rtl/bzs_axis.sv =====
// One coordinate axis: delay control points, multiply by weights, sum and round.
module bzs_axis (
    input  logic               aclk,
    input  bzs_pkg::pipe_ctl_t ctl,
    input  bzs_pkg::coord_t    ctrl [bzs_pkg::NUM_CTRL],
    input  bzs_pkg::weight_t   weight [bzs_pkg::NUM_CTRL],
    output bzs_pkg::pos_t      pos
);

    localparam int SH_W = bzs_pkg::ACC_W - bzs_pkg::RND_SHIFT;
    localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((2 ** (bzs_pkg::OUT_BITS - 1)) - 1);
    localparam logic signed [SH_W-1:0] SAT_LO = -SH_W'(2 ** (bzs_pkg::OUT_BITS - 1));
    localparam logic signed [bzs_pkg::SUM_W-1:0] RND =
        bzs_pkg::SUM_W'(2 ** (bzs_pkg::RND_SHIFT - 1));

    bzs_pkg::coord_t p1_reg [bzs_pkg::NUM_CTRL];
    bzs_pkg::coord_t p2_reg [bzs_pkg::NUM_CTRL];
    bzs_pkg::coord_t p3_reg [bzs_pkg::NUM_CTRL];

    logic signed [bzs_pkg::PROD_W-1:0] prod_reg [bzs_pkg::NUM_CTRL];
    logic signed [bzs_pkg::SUM_W-1:0]  s01_reg, s23_reg;
    bzs_pkg::pos_t                     pos_reg, pos_next;

    logic signed [bzs_pkg::ACC_W-1:0] acc;
    logic signed [SH_W-1:0]           scaled;

    // Stages 1 to 3: hold the points alongside the weight pipeline
    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            p1_reg <= ctrl;
        end
        if (ctl.load[1]) begin
            p2_reg <= p1_reg;
        end
        if (ctl.load[2]) begin
            p3_reg <= p2_reg;
        end
    end

    // Stage 4: weighted terms
    always_ff @(posedge aclk) begin
        if (ctl.load[3]) begin
            for (int k = 0; k < bzs_pkg::NUM_CTRL; k++) begin
                prod_reg[k] <= $signed({1'b0, weight[k]}) * p3_reg[k];
            end
        end
    end

    // Stage 5: pair sums, rounding offset folded into the first pair
    always_ff @(posedge aclk) begin
        if (ctl.load[4]) begin
            s01_reg <= bzs_pkg::SUM_W'(prod_reg[0]) + bzs_pkg::SUM_W'(prod_reg[1]) + RND;
            s23_reg <= bzs_pkg::SUM_W'(prod_reg[2]) + bzs_pkg::SUM_W'(prod_reg[3]);
        end
    end

    // Stage 6: final sum, drop the extra fraction bits, saturate
    always_comb begin
        acc    = bzs_pkg::ACC_W'(s01_reg) + bzs_pkg::ACC_W'(s23_reg);
        scaled = acc[bzs_pkg::ACC_W-1:bzs_pkg::RND_SHIFT];
        if (scaled > SAT_HI) begin
            pos_next = SAT_HI[bzs_pkg::OUT_BITS-1:0];
        end else if (scaled < SAT_LO) begin
            pos_next = SAT_LO[bzs_pkg::OUT_BITS-1:0];
        end else begin
            pos_next = scaled[bzs_pkg::OUT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[5]) begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

// ===== rtl/bezier_curve_sampler_unit.sv =====
// Top level of the Bezier curve sampler: stream handshake and six-stage pipeline.
// Six stages lie between an input transfer and m_tvalid of its result.
// Throughput: one point per cycle while m_tready is high; stages (index clamp, squares,
// weights, weighted terms, pair sums, final sum and round) take a new item each cycle.
// A stage that holds data while the next one is stalled keeps it; bubbles fill up.
// Reset (aresetn low, synchronous) clears the stage valid bits only; data is not reset.
`include "bezier_curve_sampler_unit_assert.svh"

module bezier_curve_sampler_unit (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    // ctrl0_x[15:0], ctrl0_y[31:16], ctrl1_x[47:32], ctrl1_y[63:48],
    // ctrl2_x[79:64], ctrl2_y[95:80], ctrl3_x[111:96], ctrl3_y[127:112],
    // sample_index[136:128], zero fill[143:137]
    input  logic [143:0] s_tdata,
    // opcode[0]: 0 quadratic, 1 cubic
    input  logic [0:0]   s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x[23:0], pos_y[47:24]
    output logic [47:0]  m_tdata
);

    localparam int CW = bzs_pkg::COORD_BITS;

    logic [bzs_pkg::NUM_STAGES-1:0] valid_reg, valid_next;
    logic [bzs_pkg::NUM_STAGES-1:0] load;
    bzs_pkg::pipe_ctl_t             ctl;

    bzs_pkg::coord_t  ctrl_x [bzs_pkg::NUM_CTRL];
    bzs_pkg::coord_t  ctrl_y [bzs_pkg::NUM_CTRL];
    bzs_pkg::weight_t weight [bzs_pkg::NUM_CTRL];
    bzs_pkg::op_t     opcode;
    bzs_pkg::idx_t    sample_index;
    bzs_pkg::pos_t    pos_x, pos_y;

    // Unpack the input transfer: points alternate x, y from the low end.
    always_comb begin
        for (int k = 0; k < bzs_pkg::NUM_CTRL; k++) begin
            ctrl_x[k] = s_tdata[(2 * k) * CW +: CW];
            ctrl_y[k] = s_tdata[(2 * k + 1) * CW +: CW];
        end
        sample_index = s_tdata[2 * bzs_pkg::NUM_CTRL * CW +: bzs_pkg::IDX_W];
        opcode       = bzs_pkg::op_t'(s_tuser[0]);
    end

    // A stage loads when it is empty or when its contents move on this cycle.
    always_comb begin
        load[bzs_pkg::NUM_STAGES-1] = !valid_reg[bzs_pkg::NUM_STAGES-1] || m_tready;
        for (int k = bzs_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        valid_next = valid_reg;
        if (load[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < bzs_pkg::NUM_STAGES; k++) begin
            if (load[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.load = load;

    bzs_weights u_weights (
        .aclk         (aclk),
        .ctl          (ctl),
        .opcode       (opcode),
        .sample_index (sample_index),
        .weight       (weight)
    );

    bzs_axis u_axis_x (
        .aclk   (aclk),
        .ctl    (ctl),
        .ctrl   (ctrl_x),
        .weight (weight),
        .pos    (pos_x)
    );

    bzs_axis u_axis_y (
        .aclk   (aclk),
        .ctl    (ctl),
        .ctrl   (ctrl_y),
        .weight (weight),
        .pos    (pos_y)
    );

    assign s_tready = load[0];
    assign m_tvalid = valid_reg[bzs_pkg::NUM_STAGES-1];
    assign m_tdata  = {pos_y, pos_x};

    // An accepted transfer occupies the first stage on the next edge.
    `BZS_ASSERT(a_accept_enters, aclk, aresetn, (s_tvalid && s_tready) |=> valid_reg[0])
    // With the sink ready the whole pipeline advances, so input is never blocked.
    `BZS_ASSERT(a_sink_ready_flows, aclk, aresetn, m_tready |-> s_tready)
    // A stalled stage keeps its item.
    `BZS_ASSERT(a_stall_keeps, aclk, aresetn, (valid_reg[3] && !load[3]) |=> valid_reg[3])
    // Reset empties every stage.
    `BZS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> (valid_reg == '0))

endmodule

// ===== bench/bezier_curve_sampler_checker.sv =====
// Checker for the Bezier curve sampler: predicts each curve point and compares the results.
`timescale 1ns / 100ps

module bezier_curve_sampler_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [47:0]  m_tdata,
    output int           n_errors,
    output int           n_pending,
    output int           n_checked
);

    typedef struct packed {
        bzs_pkg::pos_t y;
        bzs_pkg::pos_t x;
    } point_t;

    point_t expected_points[$];
    int     mismatches = 0;
    int     checked    = 0;

    // One coordinate of the curve point. The divisor is SAMPLE_DIV to the curve order,
    // a power of two, so the half-up rounded quotient is an arithmetic right shift.
    function automatic bzs_pkg::pos_t curve_coord(bzs_pkg::op_t op, bzs_pkg::coord_t a,
                                                  bzs_pkg::coord_t b, bzs_pkg::coord_t c,
                                                  bzs_pkg::coord_t d, bzs_pkg::idx_t idx);
        longint t;
        longint u;
        longint acc;
        longint scaled;
        int     shift;
        t = idx;
        if (t > bzs_pkg::SAMPLE_DIV)
            t = bzs_pkg::SAMPLE_DIV;
        u = bzs_pkg::SAMPLE_DIV - t;
        if (op == bzs_pkg::OP_CUBIC) begin
            acc   = u * u * u * a + 3 * u * u * t * b + 3 * u * t * t * c + t * t * t * d;
            shift = 3 * bzs_pkg::DIV_LOG2;
        end else begin
            acc   = u * u * a + 2 * u * t * b + t * t * c;
            shift = 2 * bzs_pkg::DIV_LOG2;
        end
        scaled = ((acc <<< bzs_pkg::FRAC_BITS) + (longint'(1) <<< (shift - 1))) >>> shift;
        if (scaled > (longint'(1) <<< (bzs_pkg::OUT_BITS - 1)) - 1)
            scaled = (longint'(1) <<< (bzs_pkg::OUT_BITS - 1)) - 1;
        if (scaled < -(longint'(1) <<< (bzs_pkg::OUT_BITS - 1)))
            scaled = -(longint'(1) <<< (bzs_pkg::OUT_BITS - 1));
        return bzs_pkg::pos_t'(scaled);
    endfunction

    function automatic point_t curve_point(bzs_pkg::op_t op, logic [143:0] data);
        bzs_pkg::coord_t c [8];
        bzs_pkg::idx_t   idx;
        point_t          p;
        for (int k = 0; k < 8; k++)
            c[k] = data[16*k +: 16];
        idx = data[128 +: bzs_pkg::IDX_W];
        p.x = curve_coord(op, c[0], c[2], c[4], c[6], idx);
        p.y = curve_coord(op, c[1], c[3], c[5], c[7], idx);
        return p;
    endfunction

    always @(posedge aclk) begin
        point_t want;
        point_t got;
        if (aresetn) begin
            // Predict each accepted input point.
            if (s_tvalid && s_tready)
                expected_points.push_back(curve_point(bzs_pkg::op_t'(s_tuser[0]), s_tdata));
            // Compare each accepted result with the oldest prediction.
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_points.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result x=%0d y=%0d", got.x, got.y);
                end else begin
                    want = expected_points.pop_front();
                    checked++;
                    if (got.x !== want.x || got.y !== want.y) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: point %0d: expected x=%0d y=%0d, got x=%0d y=%0d",
                                     checked, want.x, want.y, got.x, got.y);
                    end
                end
            end
        end
        n_errors  <= mismatches;
        n_pending <= expected_points.size();
        n_checked <= checked;
    end

endmodule

// ===== bench/tb_bezier_curve_sampler_unit.sv =====
// Testbench top for the Bezier curve sampler: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_bezier_curve_sampler_unit;

    localparam int RAND_PER_PHASE = 184;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 20;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata  = '0;
    logic [0:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;

    int n_errors;
    int n_pending;
    int n_checked;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycles         = 0;
    int n_quad         = 0;
    int n_cubic        = 0;
    int n_past_end     = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bezier_curve_sampler_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bezier_curve_sampler_checker i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .n_errors  (n_errors),
        .n_pending (n_pending),
        .n_checked (n_checked)
    );

    // Stall the result channel at random, at the rate of the current phase.
    always @(negedge aclk)
        m_tready = ($urandom_range(99) >= recv_stall_pct);

    // Abort a hung run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d results missing", cycles, n_pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Mostly full-range coordinates, with the extremes and values near zero mixed in.
    function automatic bzs_pkg::coord_t rand_coord();
        case ($urandom_range(19))
            0:       return bzs_pkg::coord_t'(16'h8000);
            1:       return bzs_pkg::coord_t'(16'h7fff);
            2:       return bzs_pkg::coord_t'(0);
            3:       return bzs_pkg::coord_t'(-1);
            default: return bzs_pkg::coord_t'($urandom);
        endcase
    endfunction

    function automatic logic [127:0] rand_ctrl_points();
        logic [127:0] pts;
        for (int k = 0; k < 8; k++)
            pts[16*k +: 16] = rand_coord();
        return pts;
    endfunction

    // Mostly in-range indexes; the ends of the curve and indexes past the end too.
    function automatic bzs_pkg::idx_t rand_index();
        int pick;
        pick = $urandom_range(99);
        if (pick < 75)
            return bzs_pkg::idx_t'($urandom_range(bzs_pkg::SAMPLE_DIV));
        else if (pick < 85)
            return bzs_pkg::idx_t'($urandom_range(2 ** bzs_pkg::IDX_W - 1,
                                                  bzs_pkg::SAMPLE_DIV + 1));
        else
            case ($urandom_range(3))
                0:       return bzs_pkg::idx_t'(0);
                1:       return bzs_pkg::idx_t'(1);
                2:       return bzs_pkg::idx_t'(bzs_pkg::SAMPLE_DIV - 1);
                default: return bzs_pkg::idx_t'(bzs_pkg::SAMPLE_DIV);
            endcase
    endfunction

    // Present one sample request and hold it until transfer. Enter and leave at a falling edge.
    task automatic send_sample(bzs_pkg::op_t op, logic [127:0] pts, bzs_pkg::idx_t idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tuser  = op;
        s_tdata  = {7'b0, idx, pts};
        s_tvalid = 1'b1;
        do
            @(posedge aclk);
        while (!s_tready);
        if (op == bzs_pkg::OP_CUBIC)
            n_cubic++;
        else
            n_quad++;
        if (idx > bzs_pkg::SAMPLE_DIV)
            n_past_end++;
        @(negedge aclk);
    endtask

    // Hold off the input channel until every predicted point has come out.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (n_pending != 0)
            @(negedge aclk);
    endtask

    initial begin
        logic [127:0] alt_lo_hi;
        logic [127:0] alt_hi_lo;
        logic [127:0] base;
        bzs_pkg::op_t op;

        // ctrl0 and ctrl2 at one extreme, ctrl1 and ctrl3 at the other: widest swing.
        alt_lo_hi = {2{32'h7fff7fff, 32'h80008000}};
        alt_hi_lo = {2{32'h80008000, 32'h7fff7fff}};

        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 20;
                    recv_stall_pct = 48;
                end
                1: begin
                    send_idle_pct  = 48;
                    recv_stall_pct = 20;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase

            if (phase == 0) begin
                // Directed: extremes of coordinates and index, both curve orders.
                for (int k = 0; k < 2; k++) begin
                    op = (k == 0) ? bzs_pkg::OP_QUAD : bzs_pkg::OP_CUBIC;
                    send_sample(op, {8{16'h8000}}, bzs_pkg::idx_t'(0));
                    send_sample(op, {8{16'h7fff}}, bzs_pkg::idx_t'(bzs_pkg::SAMPLE_DIV));
                    send_sample(op, alt_lo_hi, bzs_pkg::idx_t'(bzs_pkg::SAMPLE_DIV / 2));
                    send_sample(op, alt_hi_lo, bzs_pkg::idx_t'(bzs_pkg::SAMPLE_DIV / 2));
                    send_sample(op, alt_lo_hi, bzs_pkg::idx_t'(1));
                    send_sample(op, alt_hi_lo, bzs_pkg::idx_t'(bzs_pkg::SAMPLE_DIV - 1));
                    // Index past the end clamps to the end point.
                    send_sample(op, rand_ctrl_points(),
                                bzs_pkg::idx_t'(bzs_pkg::SAMPLE_DIV + 1));
                    send_sample(op, rand_ctrl_points(),
                                bzs_pkg::idx_t'(2 ** bzs_pkg::IDX_W - 1));
                end
                // Quadratic ignores the fourth point: same curve, opposite ctrl3 extremes.
                base = rand_ctrl_points();
                send_sample(bzs_pkg::OP_QUAD, {32'h7fff7fff, base[95:0]}, bzs_pkg::idx_t'(100));
                send_sample(bzs_pkg::OP_QUAD, {32'h80008000, base[95:0]}, bzs_pkg::idx_t'(100));
                // Exact half on rounding: x lands on +127.5, y on -127.5.
                send_sample(bzs_pkg::OP_QUAD, {64'h0, 16'hffc0, 16'h0040, 32'h0},
                            bzs_pkg::idx_t'(bzs_pkg::SAMPLE_DIV - 1));
            end

            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (phase == 1 && n == RAND_PER_PHASE / 2)
                    wait_drained();
                send_sample(bzs_pkg::op_t'($urandom_range(1)), rand_ctrl_points(),
                            rand_index());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Summary: %0d curve points checked (%0d quadratic, %0d cubic, %0d past the end)",
                 n_checked, n_quad, n_cubic, n_past_end);
        $display("Summary: three flow-control phases, %0d mismatches, %0d cycles",
                 n_errors, cycles);
        if (n_errors == 0 && n_pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
